/* rtl/point_rotate_project_assert.svh */
// Assertion macros used by the checker file of the point rotation block.
`ifndef POINT_ROTATE_PROJECT_ASSERT_SVH
`define POINT_ROTATE_PROJECT_ASSERT_SVH

// Property checked at every clock edge outside of reset.
`define PRR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define PRR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/prr_pkg.sv */
// Package with the widths, register indexes and payload types of the point rotation block.
`default_nettype none
package prr_pkg;
   localparam int COORD_W  = 11;
   localparam int TRIG_W   = 16;
   localparam int BIAS_W   = 12;
   localparam int SX_W     = 9;
   localparam int SY_W     = 8;
   localparam int BRI_W    = 3;
   localparam int VZ_W     = 13;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_FIRST  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_FIRST  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_SECOND = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_SECOND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_THIRD  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_THIRD  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_BIAS     = 3'd6;

   localparam int ONE_Q14   = 16384;
   localparam int Q14_SH    = 14;
   localparam int PROD_W    = 32;   // product of two trig values
   localparam int CELL_W    = 48;   // matrix cell at scale 2^42
   localparam int TERM_W    = 59;   // cell times coordinate
   localparam int SUM_W     = 62;   // row sum plus offset
   localparam int FRAC_SH   = 42;
   localparam int Q16_SH    = 26;
   localparam int V16_W     = SUM_W - Q16_SH;
   localparam int ZF_W      = SUM_W - FRAC_SH;
   localparam int DEN_W     = 21;
   localparam int Q_W       = 17;
   localparam int F_W       = 16;
   localparam int REM_W     = 29;
   localparam int NEAR_SPAN = 600;
   localparam int BAND_STEP = 200;
   localparam int BAND_CNT  = 5;
   localparam int BRI_NEAR  = 6;
   localparam int CENTER_OFFSET = 7;
   localparam int VZ_MIN    = -4096;
   localparam int VZ_MAX    = 4095;

   typedef struct packed {
      logic signed [TRIG_W-1:0] c1;
      logic signed [TRIG_W-1:0] s1;
      logic signed [TRIG_W-1:0] c2;
      logic signed [TRIG_W-1:0] s2;
      logic signed [TRIG_W-1:0] c3;
      logic signed [TRIG_W-1:0] s3;
      logic signed [BIAS_W-1:0] bias;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] c1c2;
      logic signed [PROD_W-1:0] c1s2;
      logic signed [PROD_W-1:0] s1c3;
      logic signed [PROD_W-1:0] s1s3;
      logic signed [PROD_W-1:0] s1c2;
      logic signed [PROD_W-1:0] s1s2;
      logic signed [PROD_W-1:0] c1c3;
      logic signed [PROD_W-1:0] c1s3;
      logic signed [PROD_W-1:0] c2s3;
      logic signed [PROD_W-1:0] c2c3;
   } prods_type;

   typedef struct packed {
      logic signed [CELL_W-1:0] r00;
      logic signed [CELL_W-1:0] r01;
      logic signed [CELL_W-1:0] r02;
      logic signed [CELL_W-1:0] r10;
      logic signed [CELL_W-1:0] r11;
      logic signed [CELL_W-1:0] r12;
      logic signed [CELL_W-1:0] r20;
      logic signed [CELL_W-1:0] r21;
      logic signed [CELL_W-1:0] r22;
   } cells_type;

   typedef struct packed {
      logic signed [V16_W-1:0] x16;
      logic signed [V16_W-1:0] y16;
      logic                    behind;
      logic [BRI_W-1:0]        bri;
      logic signed [VZ_W-1:0]  vz;
   } side_type;
endpackage
`default_nettype wire

/* rtl/prr_req_if.sv */
// Interface of the point request channel.
`default_nettype none
interface prr_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [prr_pkg::COORD_W-1:0]  point_x;
   logic signed [prr_pkg::COORD_W-1:0]  point_y;
   logic signed [prr_pkg::COORD_W-1:0]  point_z;

   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   output ready);
endinterface
`default_nettype wire

/* rtl/prr_rsp_if.sv */
// Interface of the projected sprite response channel.
`default_nettype none
interface prr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [prr_pkg::SX_W-1:0]           screen_x;
   logic [prr_pkg::SY_W-1:0]           screen_y;
   logic                               behind;
   logic [prr_pkg::BRI_W-1:0]          brightness;
   logic signed [prr_pkg::VZ_W-1:0]    view_z;

   modport source (output valid, output screen_x, output screen_y, output behind,
                   output brightness, output view_z, input ready);
   modport sink   (input valid, input screen_x, input screen_y, input behind,
                   input brightness, input view_z, output ready);
endinterface
`default_nettype wire

/* rtl/prr_matrix.sv */
// Two pipeline stages that build the nine rotation matrix cells.
`default_nettype none
module prr_matrix (
   input  logic                clock,
   input  logic                reset,
   input  prr_pkg::cfg_type    cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  prr_pkg::point_type  in_point,
   output logic                out_valid,
   input  logic                out_ready,
   output prr_pkg::point_type  out_point,
   output prr_pkg::cells_type  out_cells
);
   localparam int CW  = prr_pkg::CELL_W;
   localparam int PRW = prr_pkg::PROD_W;
   localparam int SH  = prr_pkg::Q14_SH;

   logic v1_ff, v2_ff, en1, en2;
   prr_pkg::prods_type prods_in, prods_ff;
   prr_pkg::point_type pt1_ff, pt2_ff;
   prr_pkg::cells_type cells_in, cells_ff;
   logic signed [CW-1:0] t1, t2, t3, t4;

   assign en2       = !v2_ff || out_ready;
   assign en1       = !v1_ff || en2;
   assign in_ready  = en1;
   assign out_valid = v2_ff;
   assign out_point = pt2_ff;
   assign out_cells = cells_ff;

   always_comb begin
      prods_in.c1c2 = PRW'(cfg.c1) * PRW'(cfg.c2);
      prods_in.c1s2 = PRW'(cfg.c1) * PRW'(cfg.s2);
      prods_in.s1c3 = PRW'(cfg.s1) * PRW'(cfg.c3);
      prods_in.s1s3 = PRW'(cfg.s1) * PRW'(cfg.s3);
      prods_in.s1c2 = PRW'(cfg.s1) * PRW'(cfg.c2);
      prods_in.s1s2 = PRW'(cfg.s1) * PRW'(cfg.s2);
      prods_in.c1c3 = PRW'(cfg.c1) * PRW'(cfg.c3);
      prods_in.c1s3 = PRW'(cfg.c1) * PRW'(cfg.s3);
      prods_in.c2s3 = PRW'(cfg.c2) * PRW'(cfg.s3);
      prods_in.c2c3 = PRW'(cfg.c2) * PRW'(cfg.c3);
   end

   always_comb begin
      t1 = CW'(prods_ff.c1s2) * CW'(cfg.s3);
      t2 = CW'(prods_ff.c1s2) * CW'(cfg.c3);
      t3 = CW'(prods_ff.s1s2) * CW'(cfg.s3);
      t4 = CW'(prods_ff.s1s2) * CW'(cfg.c3);
      cells_in.r00 = CW'(prods_ff.c1c2) <<< SH;
      cells_in.r01 = -(t1 + (CW'(prods_ff.s1c3) <<< SH));
      cells_in.r02 = -(t2 - (CW'(prods_ff.s1s3) <<< SH));
      cells_in.r10 = CW'(prods_ff.s1c2) <<< SH;
      cells_in.r11 = -(t3 - (CW'(prods_ff.c1c3) <<< SH));
      cells_in.r12 = -(t4 + (CW'(prods_ff.c1s3) <<< SH));
      cells_in.r20 = CW'(cfg.s2) <<< (2 * SH);
      cells_in.r21 = CW'(prods_ff.c2s3) <<< SH;
      cells_in.r22 = CW'(prods_ff.c2c3) <<< SH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         prods_ff <= prods_in;
         pt1_ff   <= in_point;
      end
      if (en2) begin
         cells_ff <= cells_in;
         pt2_ff   <= pt1_ff;
      end
   end
endmodule
`default_nettype wire

/* rtl/prr_transform.sv */
// Three pipeline stages: matrix products, row sums with offsets, and depth decoding.
`default_nettype none
module prr_transform #(
   parameter int FOCAL_LENGTH = 256,
   parameter int CAMERA_Z     = -1100
) (
   input  logic                              clock,
   input  logic                              reset,
   input  prr_pkg::cfg_type                  cfg,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  prr_pkg::point_type                in_point,
   input  prr_pkg::cells_type                in_cells,
   output logic                              out_valid,
   input  logic                              out_ready,
   output prr_pkg::side_type                 out_side,
   output logic [prr_pkg::DEN_W-1:0]         out_den
);
   localparam int TW  = prr_pkg::TERM_W;
   localparam int SW  = prr_pkg::SUM_W;
   localparam int ZW  = prr_pkg::ZF_W;
   localparam int DW  = prr_pkg::DEN_W;
   localparam int VW  = prr_pkg::VZ_W;
   localparam int BW  = prr_pkg::BRI_W;
   localparam int FSH = prr_pkg::FRAC_SH;
   localparam int BAND_BASE = CAMERA_Z - prr_pkg::NEAR_SPAN;

   logic v1_ff, v2_ff, v3_ff, en1, en2, en3;
   logic signed [TW-1:0] term_in [9];
   logic signed [TW-1:0] term_ff [9];
   logic signed [SW-1:0] sx_in, sy_in, sz_in, sx_ff, sy_ff, sz_ff;
   logic signed [ZW-1:0] zf, zi;
   prr_pkg::side_type side_in, side_ff;
   logic [DW-1:0] den_in, den_ff;

   assign en3       = !v3_ff || out_ready;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign in_ready  = en1;
   assign out_valid = v3_ff;
   assign out_side  = side_ff;
   assign out_den   = den_ff;

   always_comb begin
      term_in[0] = TW'(in_cells.r00) * TW'(in_point.x);
      term_in[1] = TW'(in_cells.r01) * TW'(in_point.y);
      term_in[2] = TW'(in_cells.r02) * TW'(in_point.z);
      term_in[3] = TW'(in_cells.r10) * TW'(in_point.x);
      term_in[4] = TW'(in_cells.r11) * TW'(in_point.y);
      term_in[5] = TW'(in_cells.r12) * TW'(in_point.z);
      term_in[6] = TW'(in_cells.r20) * TW'(in_point.x);
      term_in[7] = TW'(in_cells.r21) * TW'(in_point.y);
      term_in[8] = TW'(in_cells.r22) * TW'(in_point.z);
   end

   always_comb begin
      sx_in = SW'(term_ff[0]) + SW'(term_ff[1]) + SW'(term_ff[2]);
      sy_in = SW'(term_ff[3]) + SW'(term_ff[4]) + SW'(term_ff[5])
            + (SW'(cfg.bias) <<< FSH);
      sz_in = SW'(term_ff[6]) + SW'(term_ff[7]) + SW'(term_ff[8])
            + (SW'(CAMERA_Z) <<< FSH);
   end

   // Depth decode: the floor of Z selects the brightness band, the truncated
   // value feeds the view depth and the divider denominator.
   always_comb begin
      zf = sz_ff[SW-1:FSH];
      zi = zf + ZW'(sz_ff[SW-1] && (|sz_ff[FSH-1:0]));
      side_in.x16    = sx_ff[SW-1:prr_pkg::Q16_SH];
      side_in.y16    = sy_ff[SW-1:prr_pkg::Q16_SH];
      side_in.behind = !sz_ff[SW-1];
      if (zi < prr_pkg::VZ_MIN) begin
         side_in.vz = VW'(prr_pkg::VZ_MIN);
      end else if (zi > prr_pkg::VZ_MAX) begin
         side_in.vz = VW'(prr_pkg::VZ_MAX);
      end else begin
         side_in.vz = VW'(zi);
      end
      side_in.bri = BW'(prr_pkg::BRI_NEAR);
      for (int b = prr_pkg::BAND_CNT; b >= 1; b--) begin
         if (zf < BAND_BASE + b * prr_pkg::BAND_STEP) begin
            side_in.bri = BW'(b);
         end
      end
      if (side_in.behind) begin
         side_in.bri = '0;
      end
      den_in = DW'(FOCAL_LENGTH) - DW'(zi);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         term_ff <= term_in;
      end
      if (en2) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         sz_ff <= sz_in;
      end
      if (en3) begin
         side_ff <= side_in;
         den_ff  <= den_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/prr_divider.sv */
// Restoring divider pipeline, one quotient bit per stage, for the perspective factor.
`default_nettype none
module prr_divider #(
   parameter int FOCAL_LENGTH = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [prr_pkg::DEN_W-1:0]   in_den,
   input  prr_pkg::side_type           in_side,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [prr_pkg::F_W-1:0]     out_factor,
   output prr_pkg::side_type           out_side
);
   localparam int QW = prr_pkg::Q_W;
   localparam int RW = prr_pkg::REM_W;
   localparam int DW = prr_pkg::DEN_W;
   localparam int CW = DW + QW;
   localparam int FW = prr_pkg::F_W;
   localparam logic [RW-1:0] NUMER = RW'(FOCAL_LENGTH * 65536);

   logic              v_ff    [QW];
   logic              rdy     [QW+1];
   logic [RW-1:0]     rem_ff  [QW];
   logic [QW-1:0]     quo_ff  [QW];
   logic [DW-1:0]     den_ff  [QW];
   prr_pkg::side_type side_ff [QW];

   assign rdy[QW]   = out_ready;
   assign in_ready  = rdy[0];
   assign out_valid = v_ff[QW-1];
   assign out_side  = side_ff[QW-1];
   assign out_factor = quo_ff[QW-1][QW-1] ? {FW{1'b1}} : quo_ff[QW-1][FW-1:0];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic              v_prev;
      logic [RW-1:0]     rem_prev;
      logic [QW-1:0]     quo_prev;
      logic [DW-1:0]     den_prev;
      prr_pkg::side_type side_prev;
      logic [CW-1:0]     shifted;
      logic [RW-1:0]     rem_in;
      logic [QW-1:0]     quo_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = NUMER;
         assign quo_prev  = '0;
         assign den_prev  = in_den;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign rdy[k] = !v_ff[k] || rdy[k+1];

      always_comb begin
         shifted = CW'(den_prev) << (QW - 1 - k);
         rem_in  = rem_prev;
         quo_in  = quo_prev;
         if (CW'(rem_prev) >= shifted) begin
            rem_in = RW'(CW'(rem_prev) - shifted);
            quo_in[QW-1-k] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end
endmodule
`default_nettype wire

/* rtl/prr_project.sv */
// Two pipeline stages that scale by the perspective factor and clamp to the frame.
`default_nettype none
module prr_project #(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 240,
   parameter int SPRITE_SIZE  = 15
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [prr_pkg::F_W-1:0]          in_factor,
   input  prr_pkg::side_type                in_side,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [prr_pkg::SX_W-1:0]         out_screen_x,
   output logic [prr_pkg::SY_W-1:0]         out_screen_y,
   output logic                             out_behind,
   output logic [prr_pkg::BRI_W-1:0]        out_brightness,
   output logic signed [prr_pkg::VZ_W-1:0]  out_view_z
);
   localparam int PW = prr_pkg::V16_W + prr_pkg::F_W + 1;
   localparam int AW = PW + 1;
   localparam int OW = AW - 32;
   localparam int SXW = prr_pkg::SX_W;
   localparam int SYW = prr_pkg::SY_W;

   logic v1_ff, v2_ff, en1, en2;
   logic signed [PW-1:0] px_in, py_in, px_ff, py_ff;
   prr_pkg::side_type side1_ff;
   logic [SXW-1:0] sx_in, sx_ff;
   logic [SYW-1:0] sy_in, sy_ff;
   logic [prr_pkg::BRI_W-1:0] bri_ff;
   logic signed [prr_pkg::VZ_W-1:0] vz_ff;
   logic behind_ff;

   // Adds the frame center, truncates toward zero and clamps to the sprite range.
   function automatic logic signed [OW-1:0] place(input logic signed [PW-1:0] prod,
                                                  input int frame);
      logic signed [AW-1:0] acc;
      logic signed [OW-1:0] pos;
      acc = AW'(prod) + (AW'(frame - 2 * prr_pkg::CENTER_OFFSET) <<< 31);
      pos = acc[AW-1:32] + OW'(acc[AW-1] && (|acc[31:0]));
      if (pos < 0) begin
         pos = '0;
      end else if (pos > frame - SPRITE_SIZE - 1) begin
         pos = OW'(frame - SPRITE_SIZE - 1);
      end
      return pos;
   endfunction

   assign en2            = !v2_ff || out_ready;
   assign en1            = !v1_ff || en2;
   assign in_ready       = en1;
   assign out_valid      = v2_ff;
   assign out_screen_x   = sx_ff;
   assign out_screen_y   = sy_ff;
   assign out_behind     = behind_ff;
   assign out_brightness = bri_ff;
   assign out_view_z     = vz_ff;

   always_comb begin
      px_in = PW'(in_side.x16) * $signed(PW'(in_factor));
      py_in = PW'(in_side.y16) * $signed(PW'(in_factor));
   end

   always_comb begin
      logic signed [OW-1:0] fx, fy;
      fx = place(px_ff, FRAME_WIDTH);
      fy = place(py_ff, FRAME_HEIGHT);
      sx_in = side1_ff.behind ? '0 : fx[SXW-1:0];
      sy_in = side1_ff.behind ? '0 : fy[SYW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         side1_ff <= in_side;
      end
      if (en2) begin
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         behind_ff <= side1_ff.behind;
         bri_ff    <= side1_ff.bri;
         vz_ff     <= side1_ff.vz;
      end
   end
endmodule
`default_nettype wire

/* rtl/point_rotate_project.sv */
// Top level of the point rotation and perspective projection pipeline.
`default_nettype none
// Each request carries one model point. The point is rotated by a ZYX matrix
// built from the six sine and cosine registers (signed Q2.14), the Y bias
// register and CAMERA_Z are added, and the result is projected with the
// factor FOCAL_LENGTH / (FOCAL_LENGTH - z) to a clamped sprite position with
// a depth brightness band; a point at rotated z >= 0 comes back flagged as
// behind with zero position and brightness. The block is a 24-stage pipeline
// with no state between points: one request is accepted in every cycle when
// nothing stalls. The depth of the pipeline is set by the perspective divider,
// which resolves one quotient bit per stage over 17 stages; matrix construction
// takes two stages, products, sums and depth decoding three, and scaling and
// clamping two. Every stage has its own valid bit and takes new data whenever
// it is empty or its successor moves, so bubbles close up while the response
// side stalls. Configuration registers are written through the csr port and
// must only change while no request is in flight; indexes past the last
// register are ignored.
module point_rotate_project #(
   parameter int FOCAL_LENGTH = 256,
   parameter int CAMERA_Z     = -1100,
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 240,
   parameter int SPRITE_SIZE  = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   prr_req_if.sink                             req_port,
   prr_rsp_if.source                           rsp_port,
   input  logic                                csr_wr_en,
   input  logic [prr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [prr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   localparam int TW = prr_pkg::TRIG_W;
   localparam int BW = prr_pkg::BIAS_W;

   prr_pkg::cfg_type   cfg_ff;
   prr_pkg::point_type req_point;
   prr_pkg::point_type mat_point;
   prr_pkg::cells_type mat_cells;
   prr_pkg::side_type  xf_side, div_side;
   logic [prr_pkg::DEN_W-1:0] xf_den;
   logic [prr_pkg::F_W-1:0]   div_factor;
   logic mat_valid, mat_ready, xf_valid, xf_ready, div_valid, div_ready;

   // Register file. The reset values give the identity rotation.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.c1   <= TW'(prr_pkg::ONE_Q14);
         cfg_ff.s1   <= '0;
         cfg_ff.c2   <= TW'(prr_pkg::ONE_Q14);
         cfg_ff.s2   <= '0;
         cfg_ff.c3   <= TW'(prr_pkg::ONE_Q14);
         cfg_ff.s3   <= '0;
         cfg_ff.bias <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            prr_pkg::CSR_COS_FIRST: begin
               cfg_ff.c1 <= csr_wdata[TW-1:0];
            end
            prr_pkg::CSR_SIN_FIRST: begin
               cfg_ff.s1 <= csr_wdata[TW-1:0];
            end
            prr_pkg::CSR_COS_SECOND: begin
               cfg_ff.c2 <= csr_wdata[TW-1:0];
            end
            prr_pkg::CSR_SIN_SECOND: begin
               cfg_ff.s2 <= csr_wdata[TW-1:0];
            end
            prr_pkg::CSR_COS_THIRD: begin
               cfg_ff.c3 <= csr_wdata[TW-1:0];
            end
            prr_pkg::CSR_SIN_THIRD: begin
               cfg_ff.s3 <= csr_wdata[TW-1:0];
            end
            prr_pkg::CSR_Y_BIAS: begin
               cfg_ff.bias <= csr_wdata[BW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_point.x = req_port.point_x;
   assign req_point.y = req_port.point_y;
   assign req_point.z = req_port.point_z;

   prr_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_port.valid),
      .in_ready  (req_port.ready),
      .in_point  (req_point),
      .out_valid (mat_valid),
      .out_ready (mat_ready),
      .out_point (mat_point),
      .out_cells (mat_cells)
   );

   prr_transform #(
      .FOCAL_LENGTH (FOCAL_LENGTH),
      .CAMERA_Z     (CAMERA_Z)
   ) u_transform (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mat_valid),
      .in_ready  (mat_ready),
      .in_point  (mat_point),
      .in_cells  (mat_cells),
      .out_valid (xf_valid),
      .out_ready (xf_ready),
      .out_side  (xf_side),
      .out_den   (xf_den)
   );

   prr_divider #(
      .FOCAL_LENGTH (FOCAL_LENGTH)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (xf_valid),
      .in_ready   (xf_ready),
      .in_den     (xf_den),
      .in_side    (xf_side),
      .out_valid  (div_valid),
      .out_ready  (div_ready),
      .out_factor (div_factor),
      .out_side   (div_side)
   );

   prr_project #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .SPRITE_SIZE  (SPRITE_SIZE)
   ) u_project (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (div_valid),
      .in_ready       (div_ready),
      .in_factor      (div_factor),
      .in_side        (div_side),
      .out_valid      (rsp_port.valid),
      .out_ready      (rsp_port.ready),
      .out_screen_x   (rsp_port.screen_x),
      .out_screen_y   (rsp_port.screen_y),
      .out_behind     (rsp_port.behind),
      .out_brightness (rsp_port.brightness),
      .out_view_z     (rsp_port.view_z)
   );
endmodule
`default_nettype wire

/* rtl/prr_checker.sv */
// Port checker for the point rotation block and its bind to the top level.
`default_nettype none
`include "point_rotate_project_assert.svh"
module prr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [prr_pkg::SX_W-1:0]            rsp_screen_x,
   input logic [prr_pkg::SY_W-1:0]            rsp_screen_y,
   input logic                                rsp_behind,
   input logic [prr_pkg::BRI_W-1:0]           rsp_brightness,
   input logic signed [prr_pkg::VZ_W-1:0]     rsp_view_z
);
   localparam int BRW = prr_pkg::BRI_W;
   localparam int WW  = prr_pkg::SX_W + prr_pkg::SY_W + 1 + prr_pkg::BRI_W + prr_pkg::VZ_W;

   logic          blank;
   logic          front_ok;
   logic [WW-1:0] rsp_word;

   assign blank    = (rsp_screen_x == '0) && (rsp_screen_y == '0) && (rsp_brightness == '0);
   assign front_ok = (rsp_brightness >= BRW'(1))
                  && (rsp_brightness <= BRW'(prr_pkg::BRI_NEAR))
                  && (rsp_view_z[prr_pkg::VZ_W-1] || (rsp_view_z == '0));
   assign rsp_word = {rsp_screen_x, rsp_screen_y, rsp_behind, rsp_brightness, rsp_view_z};

   // A point behind the camera has no position and no brightness.
   `PRR_ASSERT(a_behind_blank, rsp_valid && rsp_behind |-> blank, "behind response not blank")

   // A visible point lies in front, so its depth is not positive and its band is valid.
   `PRR_ASSERT(a_front_band, rsp_valid && !rsp_behind |-> front_ok, "front response bad band")

   // A stalled response stays put.
   `PRR_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word), "stall lost")

   // The pipeline is empty right after reset.
   `PRR_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid, "response valid after reset")
endmodule

bind point_rotate_project prr_checker u_prr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .rsp_screen_x   (rsp_port.screen_x),
   .rsp_screen_y   (rsp_port.screen_y),
   .rsp_behind     (rsp_port.behind),
   .rsp_brightness (rsp_port.brightness),
   .rsp_view_z     (rsp_port.view_z)
);
`default_nettype wire
